>>> src/efa_pkg.sv
package efa_pkg;

  localparam logic       OP_ALLOC = 1'b0;
  localparam logic       OP_FREE  = 1'b1;

  localparam logic [1:0] STAT_DONE = 2'd0;
  localparam logic [1:0] STAT_OOM  = 2'd1;
  localparam logic [1:0] STAT_ZERO = 2'd2;

  localparam logic REG_CHUNK = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  localparam logic [16:0] CHUNK_RESET = 17'd4096;
  localparam logic [16:0] LIMIT_RESET = 17'd65536;
  localparam logic [31:0] BREAK_RESET = 32'd4120;
  localparam logic [31:0] SENT_OFF    = 32'd8;
  localparam logic [31:0] MIN_BLOCK   = 32'd16;
  localparam logic [3:0]  INIT_LAST   = 4'd8;

  typedef struct packed {
    logic        operation;
    logic [15:0] request_size;
    logic [15:0] block_addr;
  } efa_in_t;

  typedef struct packed {
    logic [15:0] result_addr;
    logic [1:0]  status;
  } efa_out_t;

  typedef enum logic [5:0] {
    ST_CLR, ST_INIT, ST_IDLE, ST_FIN,
    ST_FR0, ST_FR1,
    ST_TG_H, ST_TG_F,
    ST_MG0, ST_MG1, ST_MG2, ST_MG3, ST_MG4,
    ST_MB0, ST_MB1,
    ST_MC0, ST_MC1, ST_MC2,
    ST_MD0, ST_MD1, ST_MD2, ST_MD3,
    ST_PU0, ST_PU1, ST_PU2, ST_PU3, ST_PU4,
    ST_RM0, ST_RM1, ST_RM2, ST_RM3,
    ST_FF0, ST_FF1, ST_FF2, ST_FF3, ST_FF4,
    ST_GR0, ST_GR1, ST_GR2, ST_GR3,
    ST_TK0, ST_TK1, ST_TK2, ST_TK3, ST_TK4
  } efa_state_t;

  typedef struct packed {
    efa_state_t step;
    logic       accept;
  } efa_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic init_done;
    logic op_free;
    logic req_zero;
    logic addr_zero;
    logic ff_stop;
    logic fit;
    logic rd_bit0;
    logic prev_used;
    logic grow_fail;
    logic rest_big;
  } efa_sts_t;

  function automatic logic [31:0] tag_size(input logic [31:0] v);
    return {v[31:3], 3'b000};
  endfunction

  // Final layout after reset: prologue, sentinel and one 4096-byte free block.
  function automatic logic [31:0] init_addr(input logic [3:0] k);
    logic [31:0] a;
    case (k)
      4'd0: a = 32'd4;
      4'd1: a = 32'd8;
      4'd2: a = 32'd12;
      4'd3: a = 32'd16;
      4'd4: a = 32'd20;
      4'd5: a = 32'd24;
      4'd6: a = 32'd28;
      4'd7: a = 32'd4112;
      default: a = 32'd4116;
    endcase
    return a;
  endfunction

  function automatic logic [31:0] init_data(input logic [3:0] k);
    logic [31:0] d;
    case (k)
      4'd0: d = 32'd17;
      4'd1: d = 32'd24;
      4'd2: d = 32'd24;
      4'd3: d = 32'd17;
      4'd4: d = 32'd4096;
      4'd5: d = 32'd8;
      4'd6: d = 32'd8;
      4'd7: d = 32'd4096;
      default: d = 32'd1;
    endcase
    return d;
  endfunction

endpackage

>>> src/efa_ram.sv
module efa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> src/efa_ctrl.sv
module efa_ctrl import efa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  efa_sts_t sts,
  output efa_cmd_t cmd,
  output logic     busy,
  output logic     out_valid
);

  efa_state_t state_r, state_nxt;
  efa_state_t tag_ret_r, tag_ret_nxt;
  efa_state_t rem_ret_r, rem_ret_nxt;
  efa_state_t mg_ret_r, mg_ret_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLR;
      tag_ret_r <= ST_IDLE;
      rem_ret_r <= ST_IDLE;
      mg_ret_r  <= ST_IDLE;
    end else begin
      state_r   <= state_nxt;
      tag_ret_r <= tag_ret_nxt;
      rem_ret_r <= rem_ret_nxt;
      mg_ret_r  <= mg_ret_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    tag_ret_nxt = tag_ret_r;
    rem_ret_nxt = rem_ret_r;
    mg_ret_nxt  = mg_ret_r;
    cmd.step    = state_r;
    cmd.accept  = (state_r == ST_IDLE) && start;
    busy        = (state_r != ST_IDLE);
    out_valid   = (state_r == ST_FIN);
    case (state_r)
      ST_CLR:  if (sts.clr_done) state_nxt = ST_INIT;
      ST_INIT: if (sts.init_done) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (start) begin
          if (sts.op_free) begin
            state_nxt = sts.addr_zero ? ST_FIN : ST_FR0;
          end else begin
            state_nxt = sts.req_zero ? ST_FIN : ST_FF0;
          end
        end
      end
      ST_FIN:  state_nxt = ST_IDLE;
      ST_FR0:  state_nxt = ST_FR1;
      ST_FR1: begin
        state_nxt   = ST_TG_H;
        tag_ret_nxt = ST_MG0;
        mg_ret_nxt  = ST_FIN;
      end
      ST_TG_H: state_nxt = ST_TG_F;
      ST_TG_F: state_nxt = tag_ret_r;
      ST_MG0:  state_nxt = ST_MG1;
      ST_MG1:  state_nxt = ST_MG2;
      ST_MG2:  state_nxt = ST_MG3;
      ST_MG3:  state_nxt = ST_MG4;
      ST_MG4: begin
        if (sts.prev_used && sts.rd_bit0) begin
          state_nxt = ST_PU0;
        end else if (sts.prev_used) begin
          state_nxt = ST_MB0;
        end else if (sts.rd_bit0) begin
          state_nxt = ST_MC0;
        end else begin
          state_nxt = ST_MD0;
        end
      end
      ST_MB0: begin
        state_nxt   = ST_RM0;
        rem_ret_nxt = ST_MB1;
      end
      ST_MB1: begin
        state_nxt   = ST_TG_H;
        tag_ret_nxt = ST_PU0;
      end
      ST_MC0:  state_nxt = ST_MC1;
      ST_MC1:  state_nxt = ST_MC2;
      ST_MC2:  state_nxt = mg_ret_r;
      ST_MD0: begin
        state_nxt   = ST_RM0;
        rem_ret_nxt = ST_MD1;
      end
      ST_MD1:  state_nxt = ST_MD2;
      ST_MD2:  state_nxt = ST_MD3;
      ST_MD3: begin
        state_nxt   = ST_TG_H;
        tag_ret_nxt = mg_ret_r;
      end
      ST_PU0:  state_nxt = ST_PU1;
      ST_PU1:  state_nxt = ST_PU2;
      ST_PU2:  state_nxt = ST_PU3;
      ST_PU3:  state_nxt = ST_PU4;
      ST_PU4:  state_nxt = mg_ret_r;
      ST_RM0:  state_nxt = ST_RM1;
      ST_RM1:  state_nxt = ST_RM2;
      ST_RM2:  state_nxt = ST_RM3;
      ST_RM3:  state_nxt = rem_ret_r;
      ST_FF0:  state_nxt = ST_FF1;
      ST_FF1:  state_nxt = ST_FF2;
      ST_FF2:  state_nxt = sts.ff_stop ? ST_GR0 : ST_FF3;
      ST_FF3:  state_nxt = sts.fit ? ST_TK0 : ST_FF4;
      ST_FF4:  state_nxt = ST_FF2;
      ST_GR0:  state_nxt = ST_GR1;
      ST_GR1: begin
        if (sts.grow_fail) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt   = ST_TG_H;
          tag_ret_nxt = ST_GR2;
        end
      end
      ST_GR2: begin
        state_nxt  = ST_MG0;
        mg_ret_nxt = ST_GR3;
      end
      ST_GR3:  state_nxt = ST_TK0;
      ST_TK0:  state_nxt = ST_TK1;
      ST_TK1: begin
        state_nxt   = ST_RM0;
        rem_ret_nxt = ST_TK2;
      end
      ST_TK2: begin
        state_nxt   = ST_TG_H;
        tag_ret_nxt = sts.rest_big ? ST_TK3 : ST_FIN;
      end
      ST_TK3: begin
        state_nxt   = ST_TG_H;
        tag_ret_nxt = ST_TK4;
      end
      ST_TK4: begin
        state_nxt  = ST_MG0;
        mg_ret_nxt = ST_FIN;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> src/efa_dp.sv
module efa_dp import efa_pkg::*; #(
  parameter int HEAP_WORDS = 16384
) (
  input  logic        clk,
  input  logic        rst_n,
  input  efa_cmd_t    cmd,
  input  efa_in_t     in_data,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [16:0] cfg_wdata,
  output efa_sts_t    sts,
  output efa_out_t    out_data
);

  localparam int             AW        = $clog2(HEAP_WORDS);
  localparam logic [29:0]    WORDS30   = 30'(HEAP_WORDS);
  localparam logic [32:0]    CAP       = 33'(HEAP_WORDS) * 33'd4;
  localparam int             STEP_MAX  = HEAP_WORDS / 4 + 2;
  localparam int             SW        = $clog2(STEP_MAX + 1);
  localparam logic [SW-1:0]  STEP_INIT = SW'(STEP_MAX);
  localparam logic [AW-1:0]  CLR_LAST  = AW'(HEAP_WORDS - 1);

  logic [AW-1:0] clr_idx_r;
  logic [3:0]    init_k_r;
  logic [16:0]   chunk_r, limit_r;
  logic [31:0]   brk_r;
  logic          rd_ok_r;

  logic [31:0] tg_bp_r, tg_v_r, mg_bp_r, rm_p_r, tk_bp_r;
  logic [31:0] pb_r, nb_r, sz_r, pbsz_r, nbsz_r, tmp_r, ft_r;
  logic [31:0] pv_r, nx_r, last_r, p_r, have_r, gsz_r;
  logic [16:0] need_r;
  logic [SW-1:0] steps_r;
  logic        prev_used_r;
  logic [15:0] res_r;
  logic [1:0]  st_r;

  logic [31:0]   maddr, mwdata, ram_q, rdv, tg_hdr, tg_foot;
  logic          mre, mwe, in_rng, tg_inr;
  logic          ram_we;
  logic [AW-1:0] ram_idx;
  logic [31:0]   ram_wd;
  logic [32:0]   lim;
  logic [16:0]   need_in, amt;
  logic [15:0]   words;
  logic          rest_big;

  assign rdv     = rd_ok_r ? ram_q : 32'd0;
  assign in_rng  = (maddr[31:2] < WORDS30);
  assign tg_hdr  = tg_bp_r - 32'd4;
  assign tg_inr  = (tg_hdr[31:2] < WORDS30);
  // A header outside the memory reads back as zero, so the footer lands just below it.
  assign tg_foot = tg_bp_r + (tg_inr ? tag_size(tg_v_r) : 32'd0) - 32'd8;
  assign lim     = (33'(limit_r) < CAP) ? 33'(limit_r) : CAP;
  assign need_in = (in_data.request_size < 16'd8) ? 17'(MIN_BLOCK) :
                   ((17'(in_data.request_size) + 17'd15) & ~17'd7);
  assign amt      = (need_r > chunk_r) ? need_r : chunk_r;
  assign words    = 16'(amt[16:2]) + 16'd1;
  assign rest_big = ((have_r - 32'(need_r)) >= MIN_BLOCK);

  always_comb begin
    maddr  = 32'd0;
    mwdata = 32'd0;
    mre    = 1'b0;
    mwe    = 1'b0;
    case (cmd.step)
      ST_INIT: begin mwe = 1'b1; maddr = init_addr(init_k_r); mwdata = init_data(init_k_r); end
      ST_FR0:  begin mre = 1'b1; maddr = tg_bp_r - 32'd4; end
      ST_TG_H: begin mwe = 1'b1; maddr = tg_hdr; mwdata = tg_v_r; end
      ST_TG_F: begin mwe = 1'b1; maddr = tg_foot; mwdata = tg_v_r; end
      ST_MG0:  begin mre = 1'b1; maddr = mg_bp_r - 32'd8; end
      ST_MG1:  begin mre = 1'b1; maddr = mg_bp_r - 32'd4; end
      ST_MG2:  begin mre = 1'b1; maddr = pb_r - 32'd4; end
      ST_MG3:  begin mre = 1'b1; maddr = nb_r - 32'd4; end
      ST_MC1:  begin mwe = 1'b1; maddr = pb_r - 32'd4; mwdata = sz_r; end
      ST_MC2:  begin mwe = 1'b1; maddr = ft_r; mwdata = sz_r; end
      ST_MD1:  begin mre = 1'b1; maddr = pb_r - 32'd4; end
      ST_MD2:  begin mre = 1'b1; maddr = nb_r - 32'd4; end
      ST_PU0:  begin mre = 1'b1; maddr = SENT_OFF; end
      ST_PU1:  begin mwe = 1'b1; maddr = mg_bp_r + 32'd4; mwdata = SENT_OFF; end
      ST_PU2:  begin mwe = 1'b1; maddr = mg_bp_r; mwdata = last_r; end
      ST_PU3:  begin mwe = 1'b1; maddr = last_r + 32'd4; mwdata = mg_bp_r; end
      ST_PU4:  begin mwe = 1'b1; maddr = SENT_OFF; mwdata = mg_bp_r; end
      ST_RM0:  begin mre = 1'b1; maddr = rm_p_r; end
      ST_RM1:  begin mre = 1'b1; maddr = rm_p_r + 32'd4; end
      ST_RM2:  begin mwe = 1'b1; maddr = rdv; mwdata = pv_r; end
      ST_RM3:  begin mwe = 1'b1; maddr = pv_r + 32'd4; mwdata = nx_r; end
      ST_FF0:  begin mre = 1'b1; maddr = SENT_OFF; end
      ST_FF2:  begin mre = 1'b1; maddr = p_r - 32'd4; end
      ST_FF3:  begin mre = 1'b1; maddr = p_r; end
      ST_GR2:  begin mwe = 1'b1; maddr = tg_bp_r + gsz_r - 32'd4; mwdata = 32'd1; end
      ST_TK0:  begin mre = 1'b1; maddr = tk_bp_r - 32'd4; end
      default: ;
    endcase
  end

  assign ram_we  = (cmd.step == ST_CLR) || (mwe && in_rng);
  assign ram_idx = (cmd.step == ST_CLR) ? clr_idx_r : maddr[AW+1:2];
  assign ram_wd  = (cmd.step == ST_CLR) ? 32'd0 : mwdata;

  efa_ram #(.WIDTH(32), .DEPTH(HEAP_WORDS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_idx),
    .wdata (ram_wd),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
      init_k_r  <= '0;
      chunk_r   <= CHUNK_RESET;
      limit_r   <= LIMIT_RESET;
      brk_r     <= BREAK_RESET;
      rd_ok_r   <= 1'b0;
    end else begin
      rd_ok_r <= mre && in_rng;
      if (cmd.step == ST_CLR) begin
        clr_idx_r <= clr_idx_r + AW'(1);
      end
      if (cmd.step == ST_INIT) begin
        init_k_r <= init_k_r + 4'd1;
      end
      if (cmd.step == ST_GR1 && !sts.grow_fail) begin
        brk_r <= brk_r + gsz_r;
      end
      if (cfg_we) begin
        if (cfg_addr == REG_CHUNK) begin
          chunk_r <= cfg_wdata;
        end else begin
          limit_r <= cfg_wdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.step)
      ST_IDLE: begin
        if (cmd.accept) begin
          tg_bp_r <= 32'(in_data.block_addr);
          mg_bp_r <= 32'(in_data.block_addr);
          need_r  <= need_in;
          res_r   <= 16'd0;
          st_r    <= (in_data.operation == OP_ALLOC && in_data.request_size == 16'd0) ?
                     STAT_ZERO : STAT_DONE;
        end
      end
      ST_FR1: tg_v_r <= tag_size(rdv);
      ST_MG1: pb_r <= mg_bp_r - tag_size(rdv);
      ST_MG2: begin
        sz_r <= tag_size(rdv);
        nb_r <= mg_bp_r + tag_size(rdv);
      end
      ST_MG3: begin
        prev_used_r <= rdv[0];
        pbsz_r      <= tag_size(rdv);
      end
      ST_MG4: nbsz_r <= tag_size(rdv);
      ST_MB0: begin
        sz_r   <= sz_r + nbsz_r;
        rm_p_r <= nb_r;
      end
      ST_MB1: begin
        tg_bp_r <= mg_bp_r;
        tg_v_r  <= sz_r;
      end
      ST_MC0: begin
        sz_r <= sz_r + pbsz_r;
        ft_r <= mg_bp_r + sz_r - 32'd8;
      end
      ST_MC2: mg_bp_r <= pb_r;
      ST_MD0: rm_p_r <= nb_r;
      ST_MD2: tmp_r <= tag_size(rdv);
      ST_MD3: begin
        // Both neighbour sizes are read again after the unlink, which may have touched them.
        tg_v_r  <= sz_r + tmp_r + tag_size(rdv);
        tg_bp_r <= pb_r;
        mg_bp_r <= pb_r;
      end
      ST_PU1: last_r <= rdv;
      ST_RM1: pv_r <= rdv;
      ST_RM2: nx_r <= rdv;
      ST_FF1: begin
        p_r     <= rdv;
        steps_r <= STEP_INIT;
      end
      ST_FF3: tk_bp_r <= p_r;
      ST_FF4: begin
        p_r     <= rdv;
        steps_r <= steps_r - SW'(1);
      end
      ST_GR0: gsz_r <= 32'({words[15:1], 3'b000});
      ST_GR1: begin
        if (sts.grow_fail) begin
          st_r <= STAT_OOM;
        end else begin
          tg_bp_r <= brk_r;
          tg_v_r  <= gsz_r;
        end
      end
      ST_GR2: mg_bp_r <= tg_bp_r;
      ST_GR3: tk_bp_r <= mg_bp_r;
      ST_TK1: begin
        have_r <= tag_size(rdv);
        rm_p_r <= tk_bp_r;
      end
      ST_TK2: begin
        res_r   <= tk_bp_r[15:0];
        tg_bp_r <= tk_bp_r;
        tg_v_r  <= rest_big ? (32'(need_r) | 32'd1) : (have_r | 32'd1);
      end
      ST_TK3: begin
        tg_bp_r <= tk_bp_r + 32'(need_r);
        tg_v_r  <= have_r - 32'(need_r);
      end
      ST_TK4: mg_bp_r <= tg_bp_r;
      default: ;
    endcase
  end

  always_comb begin
    sts.clr_done  = (clr_idx_r == CLR_LAST);
    sts.init_done = (init_k_r == INIT_LAST);
    sts.op_free   = (in_data.operation == OP_FREE);
    sts.req_zero  = (in_data.request_size == 16'd0);
    sts.addr_zero = (in_data.block_addr == 16'd0);
    sts.ff_stop   = (p_r == SENT_OFF) || (steps_r == '0);
    sts.fit       = (tag_size(rdv) >= 32'(need_r));
    sts.rd_bit0   = rdv[0];
    sts.prev_used = prev_used_r;
    sts.grow_fail = ((33'(brk_r) + 33'(gsz_r)) > lim);
    sts.rest_big  = rest_big;
  end

  assign out_data.result_addr = res_r;
  assign out_data.status      = st_r;

endmodule

>>> src/explicit_free_list_allocator_top.sv
// Zero-size allocate and null free answer without touching memory; any other free merges
// the block with its free neighbours. Allocate walks the free list node by node and takes
// the first block that fits, splitting it when the rest is big enough; if the walk ends
// without a fit it grows the heap, and a failed growth answers with no address. One
// transaction at a time: busy falls in the cycle after the strobe. After reset the heap is
// cleared and laid out, with busy high throughout. The receiver cannot stall.
module explicit_free_list_allocator_top import efa_pkg::*; #(
  parameter int HEAP_WORDS = 16384
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  efa_in_t     in_data,
  output logic        out_valid,
  output efa_out_t    out_data,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [16:0] cfg_wdata
);

  efa_cmd_t cmd;
  efa_sts_t sts;

  efa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  efa_dp #(.HEAP_WORDS(HEAP_WORDS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .sts       (sts),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_result_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!busy && !out_valid))
    else $error("result strobe not followed by idle");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == STAT_DONE || out_data.status == STAT_OOM ||
                   out_data.status == STAT_ZERO))
    else $error("unknown status code");

  a_fail_null: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != STAT_DONE) |-> (out_data.result_addr == 16'd0))
    else $error("failed allocation returned an address");
`endif

endmodule
